// ===== sv/tse_pkg.sv =====
// Package with shared constants and types for the TCP sequence/timestamp extractor.
`default_nettype none
package tse_pkg;
	localparam int MaxFrameBytes = 4096;
	localparam int OffW = 13;
	localparam logic [15:0] EthIpv4 = 16'h0800;
	localparam logic [15:0] EthIpv6 = 16'h86DD;
	localparam logic [7:0] OptTsKind = 8'd8;
	localparam logic [7:0] OptTsLen = 8'd10;
	localparam logic [0:0] CfgDestPort = 1'b0;
	localparam logic [0:0] CfgTsEnable = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE, PH_HDR, PH_KIND, PH_LEN_TS, PH_LEN_OTHER, PH_TSVAL, PH_STOP, PH_FOUND
	} phase_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} in_item_t;

	typedef struct packed {
		logic        matched;
		logic        is_ipv6;
		logic [31:0] seq_number;
		logic        ts_found;
		logic [31:0] ts_value;
		logic        ts_disabled;
	} out_item_t;
endpackage
`default_nettype wire

// ===== sv/tse_if.sv =====
// Stream and configuration interfaces of the extractor.
`default_nettype none
interface tse_in_if import tse_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tse_out_if import tse_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tse_cfg_if ();
	logic        valid;
	logic        ready;
	logic [31:0] index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== sv/tcp_seq_timestamp_extractor.sv =====
// Top level of the TCP sequence number and timestamp extractor.
`default_nettype none
// The block takes one Ethernet frame byte per item and can accept an item in
// every cycle. Each byte updates the parse state with a single pass of short
// logic: offset compare, ethertype and IPv6 extension header walk, TCP port and
// sequence capture, and the option walk that finds the timestamp TSval. On the
// byte marked last, one result item enters the output registers behind any
// result still waiting. A second output register acts as a skid stage, so
// input keeps flowing while one result waits; input stalls only while both
// registers hold results. Bytes at offsets of 4096 and beyond are ignored.
// Write configuration only while no frame is in progress.
module tcp_seq_timestamp_extractor import tse_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	tse_in_if.sink   in_ch,
	tse_out_if.source out_ch,
	tse_cfg_if.sink  cfg
);
	logic [15:0] dest_port_q;
	logic        ts_enable_q;
	logic [OffW-1:0] off_q, hb_q, tcp_q, oend_q, onext_q;
	logic [15:0] eth_q, port_q;
	logic [7:0]  nh_q;
	phase_t      ph_q;
	logic [31:0] seq_q, ts_q;
	logic        tsdis_q;

	// Two-entry output buffer: main register and skid register.
	out_item_t   r0_q, r1_q;
	logic        v0_q, v1_q;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = !v1_q;
	assign out_ch.valid = v0_q;
	assign out_ch.data = r0_q;

	wire acc = in_ch.valid && in_ch.ready;
	wire [7:0] b = in_ch.data.frame_byte;

	function automatic logic term(input logic [7:0] n);
		return n == 8'd6 || n == 8'd17 || n == 8'd58 || n == 8'd59;
	endfunction

	logic [OffW-1:0] n_off, n_hb, n_tcp, n_oend, n_onext, rel, tsl;
	logic [15:0] n_eth, n_port;
	logic [7:0]  n_nh;
	phase_t      n_ph;
	logic [31:0] n_seq, n_ts;
	logic        n_tsdis, mt, fnd;
	out_item_t   res;

	always_comb begin
		n_off = off_q; n_hb = hb_q; n_tcp = tcp_q; n_oend = oend_q;
		n_onext = onext_q; n_eth = eth_q; n_port = port_q; n_nh = nh_q;
		n_ph = ph_q; n_seq = seq_q; n_ts = ts_q; n_tsdis = tsdis_q;
		rel = '0; tsl = '0; mt = 1'b0; fnd = 1'b0;
		if (off_q < OffW'(MaxFrameBytes)) begin
			n_off = off_q + 1'b1;
			if (off_q == 13'd12 || off_q == 13'd13) n_eth = {eth_q[7:0], b};
			if (n_eth == EthIpv4 && off_q >= 13'd14) begin
				if (off_q == 13'd14)
					n_hb = (b[3:0] >= 4'd5) ? 13'd14 + {7'd0, b[3:0], 2'b00}
						: OffW'(MaxFrameBytes);
				else if (off_q == 13'd23) n_nh = b;
				else if (off_q >= 13'd34 && off_q == hb_q && ph_q == PH_IDLE &&
					nh_q == 8'd6) begin
					n_tcp = off_q; n_ph = PH_HDR; n_port = '0;
				end
			end else if (n_eth == EthIpv6 && off_q >= 13'd14) begin
				if (off_q == 13'd20) begin
					n_nh = b; n_hb = 13'd54;
				end else if (off_q >= 13'd54 && ph_q == PH_IDLE) begin
					if (off_q == hb_q) begin
						if (term(nh_q)) begin
							if (nh_q == 8'd6) begin
								n_tcp = off_q; n_ph = PH_HDR; n_port = '0;
							end
						end else n_port = {8'd0, b};
					end else if (off_q == hb_q + 1'b1 && !term(nh_q)) begin
						n_nh = port_q[7:0];
						n_hb = hb_q + {2'd0, b, 3'b000} + 13'd8;
						n_port = '0;
					end
				end
			end
			// TCP stage uses the phase and start just decided.
			rel = off_q - n_tcp;
			if (n_ph == PH_HDR) begin
				if (rel == 13'd2 || rel == 13'd3) n_port = {n_port[7:0], b};
				else if (rel >= 13'd4 && rel <= 13'd7) n_seq = {seq_q[23:0], b};
				else if (rel == 13'd12)
					n_oend = n_tcp + ((b[7:4] < 4'd5) ? 13'd20 : {7'd0, b[7:4], 2'b00});
				else if (rel == 13'd19) begin
					n_ph = PH_KIND; n_onext = n_tcp + 13'd20;
				end
			end else if (n_ph != PH_IDLE && off_q < oend_q) begin
				unique case (ph_q)
					PH_KIND: if (off_q == onext_q) begin
						if (b == 8'd0) n_ph = PH_STOP;
						else if (b == 8'd1) n_onext = off_q + 1'b1;
						else if (off_q + 1'b1 >= oend_q) n_ph = PH_STOP;
						else n_ph = (b == OptTsKind) ? PH_LEN_TS : PH_LEN_OTHER;
					end
					PH_LEN_TS, PH_LEN_OTHER: begin
						if (b < 8'd2 || {1'b0, onext_q} + {6'd0, b} > {1'b0, oend_q})
							n_ph = PH_STOP;
						else if (ph_q == PH_LEN_TS && b == OptTsLen) begin
							n_ph = PH_TSVAL; n_ts = '0;
						end else begin
							n_onext = onext_q + {5'd0, b}; n_ph = PH_KIND;
						end
					end
					PH_TSVAL: begin
						tsl = off_q - onext_q;
						if (tsl >= 13'd2 && tsl <= 13'd5) n_ts = {ts_q[23:0], b};
						if (tsl == 13'd5) n_ph = PH_FOUND;
					end
					default: ;
				endcase
			end
		end
		mt = n_ph >= PH_KIND && n_oend <= n_off && n_port == dest_port_q;
		if (mt && ts_enable_q && !tsdis_q) begin
			if (n_ph == PH_FOUND) fnd = 1'b1;
			else n_tsdis = 1'b1;
		end
		res.matched = mt;
		res.is_ipv6 = n_eth == EthIpv6;
		res.seq_number = mt ? n_seq : '0;
		res.ts_found = fnd;
		res.ts_value = fnd ? n_ts : '0;
		res.ts_disabled = n_tsdis;
	end

	wire push = acc && in_ch.data.frame_last;
	wire pop = v0_q && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_port_q <= '0; ts_enable_q <= 1'b0;
			off_q <= '0; hb_q <= '0; tcp_q <= '0; oend_q <= '0; onext_q <= '0;
			eth_q <= '0; port_q <= '0; nh_q <= '0; ph_q <= PH_IDLE;
			seq_q <= '0; ts_q <= '0; tsdis_q <= 1'b0;
			r0_q <= '0; r1_q <= '0;
			v0_q <= 1'b0; v1_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == 32'(CfgDestPort)) dest_port_q <= cfg.wdata[15:0];
				else if (cfg.index == 32'(CfgTsEnable)) ts_enable_q <= cfg.wdata[0];
			end
			if (acc) begin
				if (in_ch.data.frame_last) begin
					off_q <= '0; hb_q <= '0; tcp_q <= '0; oend_q <= '0; onext_q <= '0;
					eth_q <= '0; port_q <= '0; nh_q <= '0; ph_q <= PH_IDLE;
					seq_q <= '0; ts_q <= '0;
					// The timestamp decision is taken only on the last byte.
					tsdis_q <= n_tsdis;
				end else begin
					off_q <= n_off; hb_q <= n_hb; tcp_q <= n_tcp; oend_q <= n_oend;
					onext_q <= n_onext; eth_q <= n_eth; port_q <= n_port; nh_q <= n_nh;
					ph_q <= n_ph; seq_q <= n_seq; ts_q <= n_ts;
				end
			end
			if (!v0_q || pop) begin
				if (v1_q) begin
					r0_q <= r1_q; v0_q <= 1'b1; v1_q <= 1'b0;
					if (push) begin r1_q <= res; v1_q <= 1'b1; end
				end else begin
					v0_q <= push;
					if (push) r0_q <= res;
				end
			end else if (push) begin
				r1_q <= res; v1_q <= 1'b1;
			end
		end
	end

	a_skid_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q) else $error("skid entry without main entry");
	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && !out_ch.ready) |=> v1_q) else $error("skid lost");
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(tsdis_q) |-> tsdis_q) else $error("flag cleared");
	a_ts_implies_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.ts_found |-> out_ch.data.matched)
		else $error("timestamp without match");
endmodule
`default_nettype wire
